>>> design/pws_pkg.sv
// Shared register map, field widths and pipeline sizing for the world-to-screen projector.
package pws_pkg;

  typedef enum logic [2:0] {
    REG_MATRIX_ROW_X = 3'd0,
    REG_MATRIX_ROW_Y = 3'd1,
    REG_MATRIX_ROW_Z = 3'd2,
    REG_MATRIX_ROW_W = 3'd3,
    REG_VIEW_ORIGIN_X = 3'd4,
    REG_VIEW_ORIGIN_Y = 3'd5,
    REG_VIEW_WIDTH   = 3'd6,
    REG_VIEW_HEIGHT  = 3'd7
  } reg_idx_t;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // matrix rows feeding clip x, clip y and clip w
  localparam int ROWSEL [3] = '{0, 1, 3};

  // front end stages before the divider, divider geometry, back end stages
  localparam int FRONT = 5;
  localparam int NUM_W = 58;      // rounded |clip| << 16 plus half divisor
  localparam int DIV_W = 41;      // |clip| after rescale to Q16.16
  localparam int STEPS = 2;       // quotient bits per divider stage
  localparam int DIV_STAGES = NUM_W / STEPS;
  localparam int BACK = 5;
  localparam int STAGES = FRONT + 1 + DIV_STAGES + BACK;

endpackage

>>> design/project_world_to_screen_core.sv
// Pipelined world-to-screen projection: matrix transform, divide by w, viewport map.
//
// Input channel (in_valid/in_ready) carries one world point world_x/y/z in signed
// Q16.16. Output channel (out_valid/out_ready) returns screen_x/y, clip_depth and
// visible for each point, in order, one result per point.
// The APB port writes the four matrix rows (64-bit, signed Q8.8 coefficients) and
// the viewport origin and size; register i sits at byte address 8*i. Write only
// when no transaction is in flight.
// Throughput: one point per cycle unless out_ready stalls the output. The 40
// register stages are 5 for the matrix product and rescale, one to build the
// dividend, 29 long-division stages that resolve two quotient bits each for x
// and y in parallel, and 5 for the viewport multiply, rounding and saturation.
// Each stage advances when it is empty or the stage after it advances, so a stall
// at out_ready fills bubbles first; in_ready drops only when every stage is full.
// Reset clears the valid bits and all configuration registers to zero.
module project_world_to_screen_core
  import pws_pkg::*;
#(
  parameter int NEAR_W_LSB = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  world_x,
  input  logic signed [31:0]  world_y,
  input  logic signed [31:0]  world_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  screen_x,
  output logic signed [31:0]  screen_y,
  output logic signed [31:0]  clip_depth,
  output logic                visible
);

  localparam int SIDE = STAGES - FRONT;
  localparam logic [DIV_W-1:0] NDC_LIMIT = DIV_W'(1) << (DIV_W - 1);

  // configuration
  logic [63:0] mat [4];
  logic [15:0] origin [2];
  logic [15:0] vsize [2];
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) mat[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        origin[i] <= '0;
        vsize[i]  <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      case (widx)
        REG_MATRIX_ROW_X:  mat[0] <= pwdata;
        REG_MATRIX_ROW_Y:  mat[1] <= pwdata;
        REG_MATRIX_ROW_Z:  mat[2] <= pwdata;
        REG_MATRIX_ROW_W:  mat[3] <= pwdata;
        REG_VIEW_ORIGIN_X: origin[0] <= pwdata[15:0];
        REG_VIEW_ORIGIN_Y: origin[1] <= pwdata[15:0];
        REG_VIEW_WIDTH:    vsize[0] <= pwdata[15:0];
        REG_VIEW_HEIGHT:   vsize[1] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MATRIX_ROW_X:  prdata = mat[0];
      REG_MATRIX_ROW_Y:  prdata = mat[1];
      REG_MATRIX_ROW_Z:  prdata = mat[2];
      REG_MATRIX_ROW_W:  prdata = mat[3];
      REG_VIEW_ORIGIN_X: prdata = DATA_W'(origin[0]);
      REG_VIEW_ORIGIN_Y: prdata = DATA_W'(origin[1]);
      REG_VIEW_WIDTH:    prdata = DATA_W'(vsize[0]);
      REG_VIEW_HEIGHT:   prdata = DATA_W'(vsize[1]);
      default:           prdata = '0;
    endcase
  end

  // stage valids and per-stage advance
  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // front end: matrix product, sum, rescale by 256 with rounding
  logic signed [31:0] pt [3];
  logic signed [47:0] prod [3][3];
  logic signed [48:0] pa [3];
  logic signed [48:0] pb [3];
  logic signed [49:0] acc [3];
  logic        [48:0] mag [3];
  logic               neg4 [3];
  logic        [DIV_W-1:0] rm [3];
  logic               neg5 [3];

  assign pt[0] = world_x;
  assign pt[1] = world_y;
  assign pt[2] = world_z;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (en[0]) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(mat[ROWSEL[r]][16*c +: 16]) * pt[c];
        end
      end
      if (en[1]) begin
        pa[r] <= 49'(prod[r][0]) + 49'(prod[r][1]);
        pb[r] <= 49'(prod[r][2]) + 49'($signed({mat[ROWSEL[r]][63:48], 16'h0}));
      end
      if (en[2]) acc[r] <= 50'(pa[r]) + 50'(pb[r]);
      if (en[3]) begin
        neg4[r] <= acc[r][49];
        mag[r]  <= acc[r][49] ? 49'(-acc[r]) : 49'(acc[r]);
      end
      if (en[4]) begin
        neg5[r] <= neg4[r];
        rm[r]   <= DIV_W'(({1'b0, mag[r]} + 50'd128) >> 8);
      end
    end
  end

  // divider pipeline, entry 0 holds the dividend
  logic [NUM_W-1:0] dq [2][DIV_STAGES+1];
  logic [DIV_W-1:0] dr [2][DIV_STAGES+1];
  logic             sg [2][DIV_STAGES+1];
  logic [DIV_W-1:0] dd [DIV_STAGES+1];
  logic [NUM_W-1:0] qn [2][DIV_STAGES];
  logic [DIV_W-1:0] rn [2][DIV_STAGES];

  // sideband carried from the dividend stage up to the stage before the output
  logic        vis_p [SIDE-1];
  logic [31:0] dep_p [SIDE-1];

  always_comb begin : div_steps
    logic [NUM_W-1:0] q;
    logic [DIV_W-1:0] r;
    logic [DIV_W:0]   rr;
    for (int j = 0; j < DIV_STAGES; j++) begin
      for (int l = 0; l < 2; l++) begin
        q = dq[l][j];
        r = dr[l][j];
        for (int s = 0; s < STEPS; s++) begin
          rr = {r, q[NUM_W-1]};
          q  = {q[NUM_W-2:0], 1'b0};
          if (rr >= {1'b0, dd[j]}) begin
            r    = DIV_W'(rr - {1'b0, dd[j]});
            q[0] = 1'b1;
          end else begin
            r = rr[DIV_W-1:0];
          end
        end
        qn[l][j] = q;
        rn[l][j] = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[FRONT]) begin
      dd[0]    <= rm[2];
      vis_p[0] <= !neg5[2] && (rm[2] > DIV_W'(NEAR_W_LSB));
      dep_p[0] <= (rm[2] > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rm[2][31:0];
      for (int l = 0; l < 2; l++) begin
        dq[l][0] <= {1'(0), rm[l], 16'h0} + NUM_W'(rm[2] >> 1);
        dr[l][0] <= '0;
        sg[l][0] <= neg5[l];
      end
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[FRONT+1+j]) begin
        dd[j+1]    <= dd[j];
        vis_p[j+1] <= vis_p[j];
        dep_p[j+1] <= dep_p[j];
        for (int l = 0; l < 2; l++) begin
          dq[l][j+1] <= qn[l][j];
          dr[l][j+1] <= rn[l][j];
          sg[l][j+1] <= sg[l][j];
        end
      end
    end
  end

  // back end: clamp ndc, scale by viewport size, halve with rounding, add origin
  localparam int B0 = FRONT + 1 + DIV_STAGES;

  logic [DIV_W-1:0]   ndc_m [2];
  logic signed [42:0] tq [2];
  logic signed [59:0] sp [2];
  logic        [58:0] spm [2];
  logic               spn [2];
  logic        [57:0] hm [2];
  logic               hn [2];
  logic        [59:0] sum [2];
  logic        [31:0] sat [2];
  logic        [31:0] sx;
  logic        [31:0] sy;
  logic        [31:0] dep;
  logic               vis;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ndc_m[l] = (dq[l][DIV_STAGES] > NUM_W'(NDC_LIMIT)) ? NDC_LIMIT
                                                        : dq[l][DIV_STAGES][DIV_W-1:0];
      sum[l] = hn[l] ? 60'({origin[l], 16'h0}) - 60'(hm[l])
                     : 60'({origin[l], 16'h0}) + 60'(hm[l]);
      if ($signed(sum[l]) > 60'sh7FFF_FFFF)        sat[l] = 32'h7FFF_FFFF;
      else if ($signed(sum[l]) < -60'sh8000_0000)  sat[l] = 32'h8000_0000;
      else                                         sat[l] = sum[l][31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en[B0]) begin
        tq[l] <= sg[l][DIV_STAGES] ? 43'sd65536 - $signed(43'(ndc_m[l]))
                                   : 43'sd65536 + $signed(43'(ndc_m[l]));
      end
      if (en[B0+1]) sp[l] <= tq[l] * $signed({1'b0, vsize[l]});
      if (en[B0+2]) begin
        spn[l] <= sp[l][59];
        spm[l] <= sp[l][59] ? 59'(-sp[l]) : 59'(sp[l]);
      end
      if (en[B0+3]) begin
        hn[l] <= spn[l];
        hm[l] <= 58'(({1'b0, spm[l]} + 60'd1) >> 1);
      end
    end
    for (int k = 0; k < BACK - 1; k++) begin
      if (en[B0+k]) begin
        vis_p[DIV_STAGES+1+k] <= vis_p[DIV_STAGES+k];
        dep_p[DIV_STAGES+1+k] <= dep_p[DIV_STAGES+k];
      end
    end
    if (en[STAGES-1]) begin
      vis <= vis_p[SIDE-2];
      dep <= vis_p[SIDE-2] ? dep_p[SIDE-2] : 32'h0;
      sx  <= vis_p[SIDE-2] ? sat[0] : 32'h0;
      sy  <= vis_p[SIDE-2] ? sat[1] : 32'h0;
    end
  end

  assign screen_x   = sx;
  assign screen_y   = sy;
  assign clip_depth = dep;
  assign visible    = vis;

  a_vis_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> $signed(clip_depth) > 0)
    else $error("visible result with non-positive depth");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> screen_x == 0 && screen_y == 0 && clip_depth == 0)
    else $error("hidden result with nonzero fields");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && (&v))
    else $error("input stalled while the pipeline has room");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
